@@ design/assert_macros.svh @@
// Assertion macros used by the port-level checker of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define EFR_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("escaped_frame_receiver check failed");

// Concurrent check that also applies during reset.
`define EFR_ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("escaped_frame_receiver check failed");

`endif

@@ design/efr_pkg.sv @@
// Types and constants shared by the frame receiver controller and datapath.
package efr_pkg;

   // Special link bytes.
   localparam logic [7:0] StartByte  = 8'hDD;
   localparam logic [7:0] EscapeByte = 8'hCC;

   // Frame buffer geometry.
   localparam int StoreDepth = 64;
   localparam int AddrWidth  = $clog2(StoreDepth);
   localparam int CountWidth = AddrWidth + 1;

   // Receiver phases.
   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SIZE,
      PH_DATA,
      PH_ESC,
      PH_READ,
      PH_SEND
   } phase_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_frame;
      logic load_length;
      logic dec_length;
      logic store_byte;
      logic start_emit_data;
      logic start_emit_empty;
      logic read_byte;
      logic advance;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_start;
      logic is_escape;
      logic length_bad;
      logic store_full;
      logic frame_done;
      logic sum_ok;
      logic payload_none;
      logic last_byte;
   } status_type;

endpackage

@@ design/efr_datapath.sv @@
// Frame receiver datapath: length, count, checksum, frame buffer and result register.
module efr_datapath #(
   parameter int MAX_FRAME = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          rx_byte,
   input  efr_pkg::cmd_type    cmd,
   output efr_pkg::status_type status,
   output logic [7:0]          payload_byte,
   output logic                end_of_packet,
   output logic                empty_packet
);

   logic [7:0]                      remaining_ff, remaining_in;
   logic [efr_pkg::CountWidth-1:0]  count_ff, count_in;
   logic [7:0]                      sum_ff, sum_in;
   logic [efr_pkg::AddrWidth-1:0]   rd_idx_ff, rd_idx_in;
   logic                            empty_ff, empty_in;
   logic [7:0]                      byte_ff;
   logic [7:0]                      store_mem [efr_pkg::StoreDepth];

   // Status decoded from the incoming byte and the frame registers.
   always_comb begin
      status.is_start     = (rx_byte == efr_pkg::StartByte);
      status.is_escape    = (rx_byte == efr_pkg::EscapeByte);
      status.length_bad   = (rx_byte == 8'd0) || (rx_byte > 8'(MAX_FRAME));
      status.store_full   = count_ff[efr_pkg::CountWidth-1];
      status.frame_done   = (8'(count_ff) + 8'd1) >= remaining_ff;
      status.sum_ok       = (sum_ff == rx_byte);
      status.payload_none = (count_ff == '0);
      status.last_byte    = empty_ff ||
                            ((efr_pkg::CountWidth'(rd_idx_ff) +
                              efr_pkg::CountWidth'(2)) == count_ff);
   end

   // Next values of the frame control registers.
   always_comb begin
      remaining_in = remaining_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rd_idx_in    = rd_idx_ff;
      empty_in     = empty_ff;
      if (cmd.clear_frame) begin
         count_in = '0;
         sum_in   = '0;
      end
      if (cmd.load_length) begin
         remaining_in = rx_byte;
      end
      if (cmd.dec_length) begin
         remaining_in = remaining_ff - 8'd1;
      end
      if (cmd.store_byte) begin
         count_in = count_ff + efr_pkg::CountWidth'(1);
         sum_in   = sum_ff + rx_byte;
      end
      if (cmd.start_emit_data) begin
         rd_idx_in = '0;
         empty_in  = 1'b0;
      end
      if (cmd.start_emit_empty) begin
         empty_in = 1'b1;
      end
      if (cmd.advance) begin
         rd_idx_in = rd_idx_ff + efr_pkg::AddrWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rd_idx_ff    <= '0;
         empty_ff     <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rd_idx_ff    <= rd_idx_in;
         empty_ff     <= empty_in;
      end
   end

   // Frame buffer write port.
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         store_mem[count_ff[efr_pkg::AddrWidth-1:0]] <= rx_byte;
      end
   end

   // Registered read port feeding the result byte.
   always_ff @(posedge clock) begin
      if (cmd.start_emit_empty) begin
         byte_ff <= 8'd0;
      end else if (cmd.read_byte) begin
         byte_ff <= store_mem[rd_idx_ff];
      end
   end

   assign payload_byte  = byte_ff;
   assign end_of_packet = status.last_byte;
   assign empty_packet  = empty_ff;

endmodule

@@ design/efr_controller.sv @@
// Frame receiver controller: phase state machine issuing datapath commands.
module efr_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  efr_pkg::status_type status,
   output efr_pkg::cmd_type    cmd
);

   efr_pkg::phase_type phase_ff, phase_in;
   logic               req_fire;
   logic               start_hit;

   assign req_fire  = req_valid && req_ready;
   assign start_hit = status.is_start && (phase_ff != efr_pkg::PH_ESC);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff) inside
         efr_pkg::PH_IDLE: begin
            if (req_fire && start_hit) begin
               phase_in = efr_pkg::PH_SIZE;
            end
         end
         efr_pkg::PH_SIZE: begin
            if (req_fire) begin
               if (start_hit) begin
                  phase_in = efr_pkg::PH_SIZE;
               end else if (status.length_bad) begin
                  phase_in = efr_pkg::PH_IDLE;
               end else begin
                  phase_in = efr_pkg::PH_DATA;
               end
            end
         end
         efr_pkg::PH_DATA, efr_pkg::PH_ESC: begin
            if (req_fire) begin
               if (start_hit) begin
                  phase_in = efr_pkg::PH_SIZE;
               end else if (phase_ff == efr_pkg::PH_DATA && status.is_escape) begin
                  phase_in = efr_pkg::PH_ESC;
               end else if (status.store_full) begin
                  phase_in = efr_pkg::PH_IDLE;
               end else if (!status.frame_done) begin
                  phase_in = efr_pkg::PH_DATA;
               end else if (!status.sum_ok) begin
                  phase_in = efr_pkg::PH_IDLE;
               end else if (status.payload_none) begin
                  phase_in = efr_pkg::PH_SEND;
               end else begin
                  phase_in = efr_pkg::PH_READ;
               end
            end
         end
         efr_pkg::PH_READ: begin
            phase_in = efr_pkg::PH_SEND;
         end
         efr_pkg::PH_SEND: begin
            if (rsp_ready) begin
               phase_in = status.last_byte ? efr_pkg::PH_IDLE : efr_pkg::PH_READ;
            end
         end
         default: begin
            phase_in = efr_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= efr_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Handshake and datapath commands.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (phase_ff) inside
         efr_pkg::PH_IDLE: begin
            req_ready       = 1'b1;
            cmd.clear_frame = req_fire && start_hit;
         end
         efr_pkg::PH_SIZE: begin
            req_ready       = 1'b1;
            cmd.clear_frame = req_fire && start_hit;
            cmd.load_length = req_fire && !start_hit && !status.length_bad;
         end
         efr_pkg::PH_DATA, efr_pkg::PH_ESC: begin
            req_ready       = 1'b1;
            cmd.clear_frame = req_fire && start_hit;
            if (req_fire && !start_hit) begin
               if (phase_ff == efr_pkg::PH_DATA && status.is_escape) begin
                  cmd.dec_length = 1'b1;
               end else if (!status.store_full) begin
                  cmd.store_byte = 1'b1;
                  if (status.frame_done && status.sum_ok) begin
                     cmd.start_emit_data  = !status.payload_none;
                     cmd.start_emit_empty = status.payload_none;
                  end
               end
            end
         end
         efr_pkg::PH_READ: begin
            cmd.read_byte = 1'b1;
         end
         efr_pkg::PH_SEND: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready && !status.last_byte;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ design/escaped_frame_receiver.sv @@
// The first result is offered after a frame-buffer read that follows acceptance of the checksum byte's request.
// Throughput: one request per cycle while receiving; each payload byte is then released through
// a frame-buffer read phase and a result phase, and requests are held off during release.
// An empty packet gives its single marker in the cycle after the checksum request is accepted.
// Reset (synchronous, active high) returns the receiver to waiting for a start byte.
// The frame buffer is not cleared; only entries written in the current frame are read.
module escaped_frame_receiver #(
   parameter int MAX_FRAME = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_end_of_packet,
   output logic       rsp_empty_packet
);

   efr_pkg::cmd_type    cmd;
   efr_pkg::status_type status;

   // Phase control.
   efr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Frame registers and buffer.
   efr_datapath #(
      .MAX_FRAME (MAX_FRAME)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .rx_byte       (req_rx_byte),
      .cmd           (cmd),
      .status        (status),
      .payload_byte  (rsp_payload_byte),
      .end_of_packet (rsp_end_of_packet),
      .empty_packet  (rsp_empty_packet)
   );

endmodule

@@ design/efr_checker.sv @@
// Port-level checks for the frame receiver and the bind that attaches them.
`include "assert_macros.svh"

module efr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_end_of_packet,
   input logic       rsp_empty_packet
);

   // A stalled result keeps its contents.
   `EFR_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_byte) && $stable(rsp_end_of_packet) && $stable(rsp_empty_packet))

   // Requests are never taken while a result is being released.
   `EFR_ASSERT_RST(a_no_overlap, clock, reset, !(req_ready && rsp_valid))

   // An empty packet marker is always the final result of its packet.
   `EFR_ASSERT_RST(a_empty_is_last, clock, reset, rsp_valid && rsp_empty_packet |-> rsp_end_of_packet)

   // Reset leaves no result pending.
   `EFR_ASSERT_CLK(a_reset_idle, clock, $past(reset) |-> !rsp_valid)

endmodule

bind escaped_frame_receiver efr_checker u_checker (.*);
